// ===== rtl/fnv_pkg.sv =====
package fnv_pkg;

   // FNV-1 64-bit constants; the prime is 2^40 + 0x1B3
   localparam logic [63:0] FNV_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
   localparam int          PRIME_HIGH_SHIFT = 40;

   localparam int          HASH_W      = 64;
   localparam int          BUCKET_W    = 32;
   localparam logic [BUCKET_W-1:0] TABLE_SIZE_RESET = 32'd2503;

   // Queue between hasher and modulo unit (depth must be a power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Restoring divider: one quotient bit per cycle
   localparam int DIV_STEPS = HASH_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [7:0] key_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [HASH_W-1:0]   hash_value;
      logic [BUCKET_W-1:0] bucket_index;
   } rsp_type;

   // Finished key hash moving through the queue
   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
   } hash_entry_type;

endpackage

// ===== rtl/fnv_front.sv =====
module fnv_front import fnv_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type        req_data,
   input  logic           queue_full,
   output hash_entry_type push
);

   logic [HASH_W-1:0] hash_ff;
   logic [HASH_W-1:0] hash_in;
   logic [HASH_W-1:0] product;
   logic [HASH_W-1:0] stepped;
   logic              accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // Multiply by the prime as shifts: 2^40 + 256 + 128 + 32 + 16 + 2 + 1
   always_comb begin
      product = (hash_ff << PRIME_HIGH_SHIFT) + (hash_ff << 8) + (hash_ff << 7)
              + (hash_ff << 5) + (hash_ff << 4) + (hash_ff << 1) + hash_ff;
      if (req_data.has_byte) begin
         stepped = product ^ {{(HASH_W-8){1'b0}}, req_data.key_byte};
      end else begin
         stepped = hash_ff;
      end
   end

   // Advance the running hash; restart it at the end of a key
   always_comb begin
      hash_in    = hash_ff;
      push.valid = 1'b0;
      push.hash  = stepped;
      if (accept) begin
         if (req_data.last) begin
            push.valid = 1'b1;
            hash_in    = FNV_OFFSET_BASIS;
         end else begin
            hash_in    = stepped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_OFFSET_BASIS;
      end else begin
         hash_ff <= hash_in;
      end
   end

endmodule

// ===== rtl/fnv_queue.sv =====
module fnv_queue import fnv_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  hash_entry_type push,
   output logic           full,
   input  logic           pop,
   output hash_entry_type head
);

   logic [HASH_W-1:0]      entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.hash  = entries_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed hashes
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.hash;
      end
   end

endmodule

// ===== rtl/fnv_modulo.sv =====
module fnv_modulo import fnv_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  hash_entry_type      head,
   output logic                pop,
   input  logic [BUCKET_W-1:0] table_size,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_DONE   = 2'd2;

   logic [1:0]            state_ff;
   logic [1:0]            state_in;
   logic [DIV_CNT_W-1:0]  count_ff;
   logic [DIV_CNT_W-1:0]  count_in;
   logic [HASH_W-1:0]     hash_ff;
   logic [HASH_W-1:0]     hash_in;
   logic [HASH_W-1:0]     shift_ff;
   logic [HASH_W-1:0]     shift_in;
   logic [BUCKET_W-1:0]   rem_ff;
   logic [BUCKET_W-1:0]   rem_in;
   logic [BUCKET_W-1:0]   divisor_ff;
   logic [BUCKET_W-1:0]   divisor_in;
   logic [BUCKET_W:0]     rem_shift;
   logic [BUCKET_W:0]     rem_diff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;
   logic                  out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_IDLE) && head.valid;

   // One restoring step: bring down the next hash bit, subtract if it fits
   assign rem_shift = {rem_ff, shift_ff[HASH_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      hash_in      = hash_ff;
      shift_in     = shift_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      // Drop the result once the receiver takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               hash_in    = head.hash;
               shift_in   = head.hash;
               rem_in     = '0;
               divisor_in = table_size;
               count_in   = '0;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            shift_in = shift_ff << 1;
            if (!rem_diff[BUCKET_W]) begin
               rem_in = rem_diff[BUCKET_W-1:0];
            end else begin
               rem_in = rem_shift[BUCKET_W-1:0];
            end
            count_in = count_ff + 1'b1;
            if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.hash_value  = hash_ff;
               rsp_data_in.bucket_index = (divisor_ff == '0) ? '0 : rem_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      hash_ff     <= hash_in;
      shift_ff    <= shift_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/fnv1_64_bucket_index_core.sv =====
// FNV-1 64-bit key hasher with bucket index.
// Request channel (req_valid / req_stall / req_data): one key byte per request,
// with has_byte (byte belongs to the key) and last (ends the key). A bare last
// request adds no byte. Bytes are hashed at one per cycle while req_stall is low.
// Response channel (rsp_valid / rsp_stall / rsp_data): one response per key,
// the 64-bit hash and the hash modulo table_size (0 when table_size is 0).
// Config channel (csr_valid / csr_ready / csr_data): writes table_size; always
// ready, write it only while no key is in flight.
// The last request of a key pushes its hash into the queue; the modulo unit
// pops it when idle, runs a restoring divider taking one bit per cycle, then
// loads the response register. Short keys are limited by the divider, longer
// keys by the byte rate. A two-entry queue holds finished hashes between the
// hasher and the divider, so hashing continues while a division runs.
// When rsp_stall is high the response holds; the divider and the queue fill
// behind it and req_stall rises once the queue is full.
// Reset (synchronous, active high) restarts the hash at the offset basis,
// empties the queue, drops any pending response, and sets table_size to 2503.
module fnv1_64_bucket_index_core import fnv_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [BUCKET_W-1:0] csr_data
);

   logic [BUCKET_W-1:0] table_size_ff;
   logic [BUCKET_W-1:0] table_size_in;
   hash_entry_type      push;
   hash_entry_type      head;
   logic                queue_full;
   logic                pop;

   assign csr_ready = 1'b1;

   // Capture table size writes
   always_comb begin
      table_size_in = table_size_ff;
      if (csr_valid && csr_ready) begin
         table_size_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   fnv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push)
   );

   fnv_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   fnv_modulo u_modulo (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .table_size (table_size_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
